FILE: design/tcb_pkg.sv
// Shared types and constants for the text cell buffer.
package tcb_pkg;

  localparam int DEF_MAX_ROWS = 32;
  localparam int DEF_MAX_COLS = 128;
  localparam int LIM_W        = 9;

  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_CLEAR = 2'd1;
  localparam logic [1:0] CMD_DRAW  = 2'd2;

  localparam logic CFG_ROWS = 1'b0;
  localparam logic CFG_COLS = 1'b1;

  localparam logic [5:0] ROWS_RESET = 6'd25;
  localparam logic [7:0] COLS_RESET = 8'd80;

  localparam logic [7:0] BLANK_SYM  = 8'h20;
  localparam logic [7:0] ATTR_SCALE = 8'd16;

  typedef struct packed {
    logic [7:0] sym;
    logic [3:0] bg;
    logic [3:0] fg;
  } cell_t;

  localparam cell_t BLANK_CELL = '{sym: BLANK_SYM, bg: 4'd0, fg: 4'd0};

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] row;
    logic [7:0] col;
    logic [7:0] symbol;
    logic [3:0] bg_color;
    logic [3:0] fg_color;
    logic       keep_symbol;
    logic       keep_bg;
    logic       keep_fg;
  } in_item_t;

  typedef struct packed {
    logic [4:0] out_row;
    logic [6:0] out_col;
    logic [7:0] out_symbol;
    logic [7:0] out_attribute;
  } out_item_t;

  typedef struct packed {
    logic cur_we;
    logic shown_we;
  } mem_wr_t;

  typedef enum logic [1:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLEAR,
    ST_OP
  } state_t;

endpackage

FILE: design/tcb_frame_mem.sv
// One frame of character cells: single write port, registered read port.
module tcb_frame_mem #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [AW-1:0]        waddr,
  input  tcb_pkg::cell_t       wdata,
  input  logic [AW-1:0]        raddr,
  output tcb_pkg::cell_t       rdata
);
  import tcb_pkg::*;

  cell_t mem [DEPTH];
  cell_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: design/tcb_cell_cmp.sv
// Cell compare unit: decides whether a cell needs redrawing and forms its attribute.
module tcb_cell_cmp (
  input  tcb_pkg::cell_t cur,
  input  tcb_pkg::cell_t shown,
  output logic           diff,
  output logic [7:0]     attribute
);
  import tcb_pkg::*;

  logic both_blank;

  always_comb begin
    both_blank = (cur.sym == BLANK_SYM) && (shown.sym == BLANK_SYM);
    if (both_blank) begin
      diff = (cur.bg != shown.bg);
    end else begin
      diff = (cur.sym != shown.sym) || (cur.bg != shown.bg) || (cur.fg != shown.fg);
    end
    attribute = 8'(8'(cur.bg) * ATTR_SCALE) + 8'(cur.fg);
  end

endmodule

FILE: design/tcb_seq.sv
// Sequencer: request handling, frame sweeps and the result register.
module tcb_seq #(
  parameter int MAX_ROWS = tcb_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS = tcb_pkg::DEF_MAX_COLS,
  parameter int RW       = 5,
  parameter int CW       = 7
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  tcb_pkg::in_item_t        in_data,
  output logic                     in_stall,
  output logic                     out_valid,
  output tcb_pkg::out_item_t       out_data,
  input  logic                     out_stall,
  input  logic [tcb_pkg::LIM_W-1:0] eff_rows,
  input  logic [tcb_pkg::LIM_W-1:0] eff_cols,
  output logic [RW+CW-1:0]         raddr,
  output logic [RW+CW-1:0]         waddr,
  output tcb_pkg::cell_t           cur_wdata,
  output tcb_pkg::cell_t           shown_wdata,
  output tcb_pkg::mem_wr_t         wr,
  input  tcb_pkg::cell_t           cur_rdata,
  input  logic                     diff,
  input  logic [7:0]               attribute
);
  import tcb_pkg::*;

  state_t    state_r, state_nxt;
  in_item_t  item_r;
  logic [RW-1:0] op_row_r, rc_r, rc_nxt, last_r_r, last_r_nxt;
  logic [CW-1:0] op_col_r, cc_r, cc_nxt, last_c_r, last_c_nxt;
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r;

  logic      in_range, sweep_done, out_free, is_draw, is_write, draw_done, load_out;
  cell_t     merged;

  assign in_range   = ({1'b0, in_data.row} < eff_rows) && ({1'b0, in_data.col} < eff_cols);
  assign sweep_done = (rc_r == last_r_r) && (cc_r == last_c_r);
  assign out_free   = !out_valid_r || !out_stall;
  assign is_draw    = (item_r.command == CMD_DRAW);
  assign is_write   = (item_r.command == CMD_WRITE);
  assign draw_done  = is_draw && (!diff || out_free);
  assign load_out   = (state_r == ST_OP) && is_draw && diff && out_free;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_INIT: begin
        if (sweep_done) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          if (in_data.command == CMD_CLEAR) begin
            if ((eff_rows != '0) && (eff_cols != '0)) state_nxt = ST_CLEAR;
          end else if ((in_data.command inside {CMD_WRITE, CMD_DRAW}) && in_range) begin
            state_nxt = ST_OP;
          end
        end
      end
      ST_CLEAR: begin
        if (sweep_done) state_nxt = ST_IDLE;
      end
      ST_OP: begin
        if (is_write || draw_done) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs and sweep counters
  always_comb begin
    in_stall    = (state_r != ST_IDLE);
    raddr       = (state_r == ST_IDLE) ? {in_data.row[RW-1:0], in_data.col[CW-1:0]}
                                       : {op_row_r, op_col_r};
    merged.sym  = item_r.keep_symbol ? cur_rdata.sym : item_r.symbol;
    merged.bg   = item_r.keep_bg     ? cur_rdata.bg  : item_r.bg_color;
    merged.fg   = item_r.keep_fg     ? cur_rdata.fg  : item_r.fg_color;
    waddr       = {rc_r, cc_r};
    cur_wdata   = BLANK_CELL;
    shown_wdata = BLANK_CELL;
    wr          = '{cur_we: 1'b0, shown_we: 1'b0};
    rc_nxt      = rc_r;
    cc_nxt      = cc_r;
    last_r_nxt  = last_r_r;
    last_c_nxt  = last_c_r;
    case (state_r)
      ST_INIT: begin
        wr = '{cur_we: 1'b1, shown_we: 1'b1};
      end
      ST_CLEAR: begin
        wr = '{cur_we: 1'b1, shown_we: 1'b0};
      end
      ST_OP: begin
        waddr       = {op_row_r, op_col_r};
        cur_wdata   = merged;
        shown_wdata = cur_rdata;
        wr          = '{cur_we: is_write, shown_we: draw_done};
      end
      default: begin
        rc_nxt     = '0;
        cc_nxt     = '0;
        last_r_nxt = RW'(eff_rows - LIM_W'(1));
        last_c_nxt = CW'(eff_cols - LIM_W'(1));
      end
    endcase
    if (state_r == ST_INIT || state_r == ST_CLEAR) begin
      if (cc_r == last_c_r) begin
        cc_nxt = '0;
        rc_nxt = rc_r + RW'(1);
      end else begin
        cc_nxt = cc_r + CW'(1);
      end
    end
    out_valid_nxt = load_out || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      rc_r        <= '0;
      cc_r        <= '0;
      last_r_r    <= RW'(MAX_ROWS - 1);
      last_c_r    <= CW'(MAX_COLS - 1);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rc_r        <= rc_nxt;
      cc_r        <= cc_nxt;
      last_r_r    <= last_r_nxt;
      last_c_r    <= last_c_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_valid) begin
      item_r   <= in_data;
      op_row_r <= in_data.row[RW-1:0];
      op_col_r <= in_data.col[CW-1:0];
    end
    if (load_out) begin
      out_data_r.out_row       <= item_r.row[4:0];
      out_data_r.out_col       <= item_r.col[6:0];
      out_data_r.out_symbol    <= cur_rdata.sym;
      out_data_r.out_attribute <= attribute;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: design/text_cell_buffer_with_delta_draw_top.sv
// Top level of the text cell buffer with delta drawing.
// Usage:
//   Input channel (in_valid / in_stall / in_data) carries one request: write a
//   cell, clear the in-use region of the current frame, or draw one cell.
//   Result channel (out_valid / out_stall / out_data) carries one redraw cell
//   for each draw request that finds a difference; other requests give none.
//   Configuration port (cfg_we / cfg_index / cfg_wdata) sets the rows and
//   columns in use; write it only while the block is idle.
// Timing:
//   Write and draw requests in range are accepted with the frame read, then
//   pass through the compare and write-back state.
//   Other non-clear requests are dropped at acceptance. A clear sweeps
//   rows*cols cells, one cell a cycle through the sweep counter on the
//   single write port. The output register loads a result as its compare ends.
// Reset: both frames are swept to black blanks, all MAX_ROWS * MAX_COLS
//   cells (4096 at default sizes), with in_stall high throughout.
// Stall: the result register holds until taken; a draw that finds a
//   difference while it is still full waits in its compare cycle.
module text_cell_buffer_with_delta_draw_top #(
  parameter int MAX_ROWS = tcb_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS = tcb_pkg::DEF_MAX_COLS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  tcb_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output tcb_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [7:0]         cfg_wdata
);
  import tcb_pkg::*;

  localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int AW    = RW + CW;
  localparam int DEPTH = MAX_ROWS * (1 << CW);

  logic [5:0]       rows_r;
  logic [7:0]       cols_r;
  logic [LIM_W-1:0] eff_rows, eff_cols;
  logic [AW-1:0]    raddr, waddr;
  cell_t            cur_wdata, shown_wdata, cur_rdata, shown_rdata;
  mem_wr_t          wr;
  logic             diff;
  logic [7:0]       attribute;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= ROWS_RESET;
      cols_r <= COLS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ROWS: rows_r <= cfg_wdata[5:0];
        CFG_COLS: cols_r <= cfg_wdata;
        default:  rows_r <= rows_r;
      endcase
    end
  end

  always_comb begin
    eff_rows = (LIM_W'(rows_r) < LIM_W'(MAX_ROWS)) ? LIM_W'(rows_r) : LIM_W'(MAX_ROWS);
    eff_cols = (LIM_W'(cols_r) < LIM_W'(MAX_COLS)) ? LIM_W'(cols_r) : LIM_W'(MAX_COLS);
  end

  tcb_frame_mem #(.DEPTH(DEPTH), .AW(AW)) u_cur_mem (
    .clk   (clk),
    .we    (wr.cur_we),
    .waddr (waddr),
    .wdata (cur_wdata),
    .raddr (raddr),
    .rdata (cur_rdata)
  );

  tcb_frame_mem #(.DEPTH(DEPTH), .AW(AW)) u_shown_mem (
    .clk   (clk),
    .we    (wr.shown_we),
    .waddr (waddr),
    .wdata (shown_wdata),
    .raddr (raddr),
    .rdata (shown_rdata)
  );

  tcb_cell_cmp u_cmp (
    .cur       (cur_rdata),
    .shown     (shown_rdata),
    .diff      (diff),
    .attribute (attribute)
  );

  tcb_seq #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS),
    .RW       (RW),
    .CW       (CW)
  ) u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_data     (in_data),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_data    (out_data),
    .out_stall   (out_stall),
    .eff_rows    (eff_rows),
    .eff_cols    (eff_cols),
    .raddr       (raddr),
    .waddr       (waddr),
    .cur_wdata   (cur_wdata),
    .shown_wdata (shown_wdata),
    .wr          (wr),
    .cur_rdata   (cur_rdata),
    .diff        (diff),
    .attribute   (attribute)
  );

endmodule
